### rtl/modular_square_root_macros.svh
// Assertion macros for the modular square root checker
`ifndef MODULAR_SQUARE_ROOT_MACROS_SVH
`define MODULAR_SQUARE_ROOT_MACROS_SVH

`define MSR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

`define MSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

### rtl/msr_pkg.sv
`default_nettype none
package msr_pkg;
   localparam int MOD_WIDTH = 31;
   localparam int MAX_SEARCH = 64;
   localparam int SEARCH_WIDTH = $clog2(MAX_SEARCH + 1);
   localparam int CNT_WIDTH = $clog2(MOD_WIDTH + 2);
   localparam logic [MOD_WIDTH-1:0] RESET_MODULUS = 31'd998244353;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_NONRES = 2'd1;
   localparam logic [1:0] STATUS_LIMIT = 2'd2;

   typedef logic [MOD_WIDTH-1:0] word_type;
endpackage
`default_nettype wire

### rtl/modular_square_root.sv
`default_nettype none
// Channel  Ports     Contents (tdata/tuser from bit 0 up)
// req      req_t*    tdata: value[30:0]
// rsp      rsp_t*    tdata: root[30:0]; tuser: status[1:0]
// csr      csr_*     data: prime_modulus[30:0]
// One value at a time through a shared bit-serial modular multiplier. An Euler test takes
// one product per exponent bit plus one per set bit; each search candidate adds one
// product and an Euler test; the final power takes four products per exponent bit plus
// five per set bit. Reset is synchronous; the modulus resets to 998244353.
// Input and csr stall while a result waits; csr is taken only with no input offered.
module modular_square_root
   import msr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,    // value[30:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,    // root[30:0]
   output logic [1:0]       rsp_tuser,    // status[1:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);
   localparam logic [4:0] S_IDLE = 5'd0, S_RED = 5'd1, S_CHK = 5'd2, S_PW_BIT = 5'd3,
      S_PW_MUL = 5'd4, S_PW_SQ = 5'd5, S_PW_END = 5'd6, S_SR_AA = 5'd7, S_SR_B = 5'd8,
      S_CI_BIT = 5'd9, S_M1 = 5'd10, S_M2 = 5'd11, S_M3 = 5'd12, S_M4 = 5'd13,
      S_M5 = 5'd14, S_M6 = 5'd15, S_Q1 = 5'd16, S_Q2 = 5'd17, S_Q3 = 5'd18,
      S_Q4 = 5'd19, S_FIN = 5'd20, S_OUT = 5'd21;
   localparam word_type W_ONE = word_type'(1);
   localparam word_type W_THREE = word_type'(3);

   logic [4:0] st_ff, st_in;
   word_type p_ff, p_in, x_ff, x_in, e_ff, e_in, base_ff, base_in, acc_ff, acc_in;
   word_type a_ff, a_in, b_ff, b_in, rr_ff, rr_in, ri_ff, ri_in, vr_ff, vr_in;
   word_type vi_ff, vi_in, t_ff, t_in, u_ff, u_in;
   logic [SEARCH_WIDTH-1:0] k_ff, k_in;
   logic search_ff, search_in;
   word_type root_ff, root_in;
   logic [1:0] stat_ff, stat_in;
   logic ov_ff, ov_in;

   logic m_start, m_done, r_start, r_done;
   word_type m_a, m_b, m_p, r_rem;

   msr_mulmod u_mul (.clock, .reset, .start(m_start), .op_a(m_a), .op_b(m_b),
      .modulus(p_ff), .done(m_done), .product(m_p));
   msr_reduce u_red (.clock, .reset, .start(r_start), .value(req_tdata[MOD_WIDTH-1:0]),
      .modulus(p_ff), .done(r_done), .remainder(r_rem));

   function automatic word_type addm(input word_type x, input word_type y, input word_type p);
      logic [MOD_WIDTH:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, p}) s = s - {1'b0, p};
      return s[MOD_WIDTH-1:0];
   endfunction

   assign req_tready = (st_ff == S_IDLE) && !ov_ff;
   assign csr_ready = (st_ff == S_IDLE) && !ov_ff && !req_tvalid;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = {1'b0, root_ff};
   assign rsp_tuser = stat_ff;

   word_type ph;
   assign ph = p_ff >> 1;

   always_comb begin
      st_in = st_ff; p_in = p_ff; x_in = x_ff; e_in = e_ff; base_in = base_ff;
      acc_in = acc_ff; a_in = a_ff; b_in = b_ff; rr_in = rr_ff; ri_in = ri_ff;
      vr_in = vr_ff; vi_in = vi_ff; t_in = t_ff; u_in = u_ff; k_in = k_ff;
      search_in = search_ff; root_in = root_ff; stat_in = stat_ff; ov_in = ov_ff;
      m_start = 1'b0; m_a = '0; m_b = '0; r_start = 1'b0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (csr_valid && csr_ready) p_in = csr_data[MOD_WIDTH-1:0];
            if (req_tvalid && req_tready) begin
               if (p_ff < W_THREE || !p_ff[0]) begin
                  root_in = '0; stat_in = STATUS_NONRES; ov_in = 1'b1;
               end else begin
                  r_start = 1'b1; st_in = S_RED;
               end
            end
         end
         S_RED: if (r_done) begin
            x_in = r_rem;
            if (r_rem == '0) begin
               root_in = '0; stat_in = STATUS_OK; st_in = S_OUT;
            end else begin
               search_in = 1'b0; base_in = r_rem; e_in = ph; acc_in = W_ONE;
               st_in = S_PW_BIT;
            end
         end
         S_PW_BIT: begin
            if (e_ff == '0) st_in = S_PW_END;
            else if (e_ff[0]) begin
               m_start = 1'b1; m_a = acc_ff; m_b = base_ff; st_in = S_PW_MUL;
            end else begin
               m_start = 1'b1; m_a = base_ff; m_b = base_ff; st_in = S_PW_SQ;
            end
         end
         S_PW_MUL: if (m_done) begin
            acc_in = m_p; m_start = 1'b1; m_a = base_ff; m_b = base_ff; st_in = S_PW_SQ;
         end
         S_PW_SQ: if (m_done) begin
            base_in = m_p; e_in = e_ff >> 1; st_in = S_PW_BIT;
         end
         S_PW_END: begin
            if (!search_ff) begin
               if (acc_ff != W_ONE) begin
                  root_in = '0; stat_in = STATUS_NONRES; st_in = S_OUT;
               end else begin
                  k_in = '0; a_in = '0; st_in = S_CHK;
               end
            end else if (acc_ff != W_ONE) begin
               rr_in = W_ONE; ri_in = '0; vr_in = a_ff; vi_in = W_ONE; e_in = ph + W_ONE;
               st_in = S_CI_BIT;
            end else begin
               k_in = k_ff + SEARCH_WIDTH'(1); a_in = addm(a_ff, W_ONE, p_ff); st_in = S_CHK;
            end
         end
         S_CHK: begin
            if (k_ff == SEARCH_WIDTH'(MAX_SEARCH)) begin
               root_in = '0; stat_in = STATUS_LIMIT; st_in = S_OUT;
            end else begin
               st_in = S_SR_AA;
            end
         end
         S_SR_AA: begin
            m_start = 1'b1; m_a = a_ff; m_b = a_ff; st_in = S_SR_B;
         end
         S_SR_B: if (m_done) begin
            b_in = addm(m_p, p_ff - x_ff, p_ff);
            base_in = addm(m_p, p_ff - x_ff, p_ff);
            e_in = ph; acc_in = W_ONE; search_in = 1'b1; st_in = S_PW_BIT;
         end
         S_CI_BIT: begin
            if (e_ff == '0) st_in = S_FIN;
            else if (e_ff[0]) begin
               m_start = 1'b1; m_a = ri_ff; m_b = vi_ff; st_in = S_M1;
            end else begin
               m_start = 1'b1; m_a = vi_ff; m_b = vi_ff; st_in = S_Q1;
            end
         end
         S_M1: if (m_done) begin
            t_in = m_p; m_start = 1'b1; m_a = rr_ff; m_b = vi_ff; st_in = S_M2;
         end
         S_M2: if (m_done) begin
            u_in = m_p; m_start = 1'b1; m_a = ri_ff; m_b = vr_ff; st_in = S_M3;
         end
         S_M3: if (m_done) begin
            ri_in = addm(u_ff, m_p, p_ff);
            m_start = 1'b1; m_a = rr_ff; m_b = vr_ff; st_in = S_M4;
         end
         S_M4: if (m_done) begin
            u_in = m_p; m_start = 1'b1; m_a = b_ff; m_b = t_ff; st_in = S_M5;
         end
         S_M5: if (m_done) begin
            rr_in = addm(u_ff, m_p, p_ff);
            m_start = 1'b1; m_a = vi_ff; m_b = vi_ff; st_in = S_Q1;
         end
         S_M6: st_in = S_Q1;
         S_Q1: if (m_done) begin
            t_in = m_p; m_start = 1'b1; m_a = addm(vr_ff, vr_ff, p_ff); m_b = vi_ff;
            st_in = S_Q2;
         end
         S_Q2: if (m_done) begin
            vi_in = m_p; m_start = 1'b1; m_a = vr_ff; m_b = vr_ff; st_in = S_Q3;
         end
         S_Q3: if (m_done) begin
            u_in = m_p; m_start = 1'b1; m_a = b_ff; m_b = t_ff; st_in = S_Q4;
         end
         S_Q4: if (m_done) begin
            vr_in = addm(u_ff, m_p, p_ff); e_in = e_ff >> 1; st_in = S_CI_BIT;
         end
         S_FIN: begin
            root_in = (rr_ff == W_ONE) ? p_ff - W_ONE : rr_ff;
            stat_in = STATUS_OK; st_in = S_OUT;
         end
         S_OUT: if (!ov_ff) begin
            ov_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         p_ff <= RESET_MODULUS;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         p_ff <= p_in;
         ov_ff <= ov_in;
      end
      x_ff <= x_in; e_ff <= e_in; base_ff <= base_in; acc_ff <= acc_in; a_ff <= a_in;
      b_ff <= b_in; rr_ff <= rr_in; ri_ff <= ri_in; vr_ff <= vr_in; vi_ff <= vi_in;
      t_ff <= t_in; u_ff <= u_in; k_ff <= k_in; search_ff <= search_in;
      root_ff <= root_in; stat_ff <= stat_in;
   end
endmodule
`default_nettype wire

### rtl/msr_mulmod.sv
`default_nettype none
// Bit-serial modular multiplier: product = a * b mod p, one bit of b per cycle (MSB first).
// Not for reduction: a mod p via a * 1 is not valid when a >= p, so operands must be < p.
module msr_mulmod
   import msr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire word_type op_a,
   input  wire word_type op_b,
   input  wire word_type modulus,
   output logic          done,
   output word_type      product
);
   logic [MOD_WIDTH+1:0] acc_ff, acc_in;
   word_type a_ff, a_in;
   word_type b_ff, b_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [MOD_WIDTH+1:0] dbl, dbl_r, add, add_r, ext_p, ext_a;

   always_comb begin
      ext_p = {2'b00, modulus};
      ext_a = {2'b00, a_ff};
      dbl = {acc_ff[MOD_WIDTH:0], 1'b0};
      dbl_r = (dbl >= ext_p) ? dbl - ext_p : dbl;
      add = dbl_r + (b_ff[MOD_WIDTH-1] ? ext_a : '0);
      add_r = (add >= ext_p) ? add - ext_p : add;
      acc_in = acc_ff;
      a_in = a_ff;
      b_in = b_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         a_in = op_a;
         b_in = op_b;
         cnt_in = CNT_WIDTH'(MOD_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = add_r;
         b_in = {b_ff[MOD_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign product = acc_ff[MOD_WIDTH-1:0];
endmodule
`default_nettype wire

### rtl/msr_reduce.sv
`default_nettype none
// Serial restoring reduction: remainder = value mod p, one bit per cycle.
module msr_reduce
   import msr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire word_type value,
   input  wire word_type modulus,
   output logic          done,
   output word_type      remainder
);
   logic [MOD_WIDTH:0] rem_ff, rem_in, sh;
   word_type v_ff, v_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      sh = {rem_ff[MOD_WIDTH-1:0], v_ff[MOD_WIDTH-1]};
      rem_in = rem_ff;
      v_in = v_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         v_in = value;
         cnt_in = CNT_WIDTH'(MOD_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = (sh >= {1'b0, modulus}) ? sh - {1'b0, modulus} : sh;
         v_in = {v_ff[MOD_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      v_ff <= v_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign remainder = rem_ff[MOD_WIDTH-1:0];
endmodule
`default_nettype wire

### rtl/msr_checker.sv
`default_nettype none
`include "modular_square_root_macros.svh"
module msr_checker
   import msr_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);
   `MSR_ASSERT_IMPL(a_status_code, clock, reset, rsp_tvalid, rsp_tuser <= STATUS_LIMIT)
   `MSR_ASSERT_IMPL(a_zero_on_fail, clock, reset, rsp_tvalid && rsp_tuser != STATUS_OK,
      rsp_tdata == '0)
   `MSR_ASSERT_IMPL(a_no_take_while_out, clock, reset, rsp_tvalid, !(req_tvalid && req_tready))
   `MSR_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
endmodule

bind modular_square_root msr_checker u_chk (.clock, .reset, .req_tvalid, .req_tready,
   .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser);
`default_nettype wire
